// File: rtl/core/sorted_unique_key_table_assert.svh
// Assertion macros used by the checker of the sorted key table.
`ifndef SORTED_UNIQUE_KEY_TABLE_ASSERT_SVH
`define SORTED_UNIQUE_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SUKT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SUKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/sukt_pkg.sv
// Shared constants, codes and types of the sorted key table.
`timescale 1ns / 1ps
package sukt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int ACT_W       = 3;
  localparam int STAT_W      = 3;
  localparam int POS_W       = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_DELETE    = 3'd1,
    ACT_SEARCH    = 3'd2,
    ACT_LIST_ASC  = 3'd3,
    ACT_LIST_DESC = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [KEY_W-1:0]  key;
  } cell_cmd_t;

endpackage

// File: rtl/core/sukt_cell.sv
// One storage cell of the key chain: holds a key, compares it, shifts with neighbors.
`timescale 1ns / 1ps
module sukt_cell (
  input  logic                             clk,
  input  sukt_pkg::cell_cmd_t              cmd,
  input  logic                             occ,
  input  logic                             left_lt,
  input  logic signed [sukt_pkg::KEY_W-1:0] left_key,
  input  logic signed [sukt_pkg::KEY_W-1:0] right_key,
  output logic                             lt,
  output logic                             eq,
  output logic signed [sukt_pkg::KEY_W-1:0] key_q
);

  logic signed [sukt_pkg::KEY_W-1:0] key_r;
  logic signed [sukt_pkg::KEY_W-1:0] key_nxt;

  assign lt    = occ && (key_r < cmd.key);
  assign eq    = occ && (key_r == cmd.key);
  assign key_q = key_r;

  // Keys are sorted, so the lt flags along the chain form a thermometer code.
  // The first cell that is not below the key is where an insert lands.
  always_comb begin
    key_nxt = key_r;
    case (cmd.op)
      sukt_pkg::CELL_INSERT: begin
        if (!lt) begin
          key_nxt = left_lt ? cmd.key : left_key;
        end
      end
      sukt_pkg::CELL_DELETE: begin
        if (!lt) begin
          key_nxt = right_key;
        end
      end
      default: begin
        key_nxt = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// File: rtl/core/sukt_rank.sv
// Turns the chain's compare flags into the key's rank and a match flag.
`timescale 1ns / 1ps
module sukt_rank (
  input  logic [sukt_pkg::TABLE_DEPTH-1:0] lt_v,
  input  logic [sukt_pkg::TABLE_DEPTH-1:0] eq_v,
  output logic [sukt_pkg::CNT_W-1:0]       rank,
  output logic                             found
);

  logic [sukt_pkg::TABLE_DEPTH-1:0] edge_v;

  // The rank is the position just past the last set bit of the thermometer.
  always_comb begin
    for (int i = 0; i < sukt_pkg::TABLE_DEPTH; i++) begin
      if (i == sukt_pkg::TABLE_DEPTH - 1) begin
        edge_v[i] = lt_v[i];
      end else begin
        edge_v[i] = lt_v[i] && !lt_v[i+1];
      end
    end
  end

  always_comb begin
    rank = '0;
    for (int i = 0; i < sukt_pkg::TABLE_DEPTH; i++) begin
      rank = rank | (edge_v[i] ? sukt_pkg::CNT_W'(i + 1) : '0);
    end
  end

  assign found = |eq_v;

endmodule

// File: rtl/core/sorted_unique_key_table.sv
// Top level of the sorted key table: cell chain, control sequencer and result register.
`timescale 1ns / 1ps
// Keeps up to 16 distinct signed 32-bit keys in ascending order in a chain of cells.
// Input channel: an item (in_action, in_key) is accepted at a rising edge where
// start is high and busy is low. Actions: insert, delete, search, list ascending,
// list descending; other codes are dropped without a result.
// Result channel: out_valid marks each result for exactly one cycle; the receiver
// cannot stall it. out_last flags the final result of an item.
// Insert, delete and search compare the key against every cell in parallel and
// shift the chain in the same cycle: the single result is registered and appears in the
// cycle after accept, and a new item may be accepted in the very next cycle.
// A list on a table of N keys raises busy while it runs and returns one key per
// cycle, first through the state register and then the result register; the next
// item is taken once busy is low. Listing is paced by one read of the chain per cycle.
// A list on an empty table gives one empty status in the cycle after accept.
// Reset (rst_n low, synchronous) empties the table and drops any list in
// progress; stored key values are not cleared since only held keys are read.
module sorted_unique_key_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [sukt_pkg::ACT_W-1:0]        in_action,
  input  logic signed [sukt_pkg::KEY_W-1:0] in_key,
  output logic                              out_valid,
  output logic [sukt_pkg::STAT_W-1:0]       out_status,
  output logic signed [sukt_pkg::KEY_W-1:0] out_key_out,
  output logic [sukt_pkg::POS_W-1:0]        out_position,
  output logic                              out_last
);

  localparam int D = sukt_pkg::TABLE_DEPTH;

  sukt_pkg::state_t                  state_r, state_nxt;
  logic [sukt_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [sukt_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic                              desc_r, desc_nxt;

  logic                              out_valid_r, out_valid_nxt;
  sukt_pkg::status_t                 out_status_r, out_status_nxt;
  logic signed [sukt_pkg::KEY_W-1:0] out_key_r, out_key_nxt;
  logic [sukt_pkg::POS_W-1:0]        out_pos_r, out_pos_nxt;
  logic                              out_last_r, out_last_nxt;

  sukt_pkg::cell_cmd_t               cmd;
  sukt_pkg::action_t                 action;
  logic                              accept;
  logic                              empty;
  logic                              full;
  logic                              list_final;
  logic [sukt_pkg::IDX_W-1:0]        last_idx;
  logic [sukt_pkg::CNT_W-1:0]        rank;
  logic                              found;

  logic [D-1:0]                      lt_v;
  logic [D-1:0]                      eq_v;
  logic signed [sukt_pkg::KEY_W-1:0] cell_key [D];

  assign action     = sukt_pkg::action_t'(in_action);
  assign busy       = (state_r == sukt_pkg::ST_LIST);
  assign accept     = start && !busy;
  assign empty      = (count_r == '0);
  assign full       = (count_r == sukt_pkg::CNT_W'(D));
  assign last_idx   = sukt_pkg::IDX_W'(count_r - sukt_pkg::CNT_W'(1));
  assign list_final = desc_r ? (idx_r == '0) : (idx_r == last_idx);

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                              left_lt;
    logic signed [sukt_pkg::KEY_W-1:0] left_key;
    logic signed [sukt_pkg::KEY_W-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_key = in_key;
    end else begin : g_body
      assign left_lt  = lt_v[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    sukt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (sukt_pkg::CNT_W'(i) < count_r),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .right_key (right_key),
      .lt        (lt_v[i]),
      .eq        (eq_v[i]),
      .key_q     (cell_key[i])
    );
  end

  sukt_rank u_rank (
    .lt_v  (lt_v),
    .eq_v  (eq_v),
    .rank  (rank),
    .found (found)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sukt_pkg::ST_IDLE: begin
        if (accept && !empty &&
            (action inside {sukt_pkg::ACT_LIST_ASC, sukt_pkg::ACT_LIST_DESC})) begin
          state_nxt = sukt_pkg::ST_LIST;
        end
      end
      sukt_pkg::ST_LIST: begin
        if (list_final) begin
          state_nxt = sukt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sukt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.op         = sukt_pkg::CELL_HOLD;
    cmd.key        = in_key;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    desc_nxt       = desc_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = sukt_pkg::STAT_OK;
    out_key_nxt    = in_key;
    out_pos_nxt    = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      sukt_pkg::ST_IDLE: begin
        if (accept) begin
          case (action)
            sukt_pkg::ACT_INSERT: begin
              out_valid_nxt = 1'b1;
              if (found) begin
                out_status_nxt = sukt_pkg::STAT_DUP;
                out_pos_nxt    = sukt_pkg::POS_W'(rank);
              end else if (full) begin
                out_status_nxt = sukt_pkg::STAT_FULL;
              end else begin
                out_pos_nxt = sukt_pkg::POS_W'(rank);
                cmd.op      = sukt_pkg::CELL_INSERT;
                count_nxt   = count_r + sukt_pkg::CNT_W'(1);
              end
            end
            sukt_pkg::ACT_DELETE, sukt_pkg::ACT_SEARCH: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_status_nxt = sukt_pkg::STAT_EMPTY;
                out_key_nxt    = '0;
              end else if (!found) begin
                out_status_nxt = sukt_pkg::STAT_NOTFOUND;
              end else begin
                out_pos_nxt = sukt_pkg::POS_W'(rank);
                if (action == sukt_pkg::ACT_DELETE) begin
                  cmd.op    = sukt_pkg::CELL_DELETE;
                  count_nxt = count_r - sukt_pkg::CNT_W'(1);
                end
              end
            end
            sukt_pkg::ACT_LIST_ASC, sukt_pkg::ACT_LIST_DESC: begin
              desc_nxt = (action == sukt_pkg::ACT_LIST_DESC);
              idx_nxt  = (action == sukt_pkg::ACT_LIST_DESC) ? last_idx : '0;
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = sukt_pkg::STAT_EMPTY;
                out_key_nxt    = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      sukt_pkg::ST_LIST: begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = cell_key[idx_r];
        out_pos_nxt   = sukt_pkg::POS_W'(idx_r);
        out_last_nxt  = list_final;
        idx_nxt       = desc_r ? idx_r - sukt_pkg::IDX_W'(1) : idx_r + sukt_pkg::IDX_W'(1);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sukt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    desc_r       <= desc_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_key_out  = out_key_r;
  assign out_position = out_pos_r;
  assign out_last     = out_last_r;

endmodule

// File: rtl/core/sukt_checker.sv
// Port-level checker of the sorted key table and its bind to the top level.
`timescale 1ns / 1ps
`include "sorted_unique_key_table_assert.svh"
module sukt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [sukt_pkg::ACT_W-1:0]        in_action,
  input logic                              out_valid,
  input logic [sukt_pkg::STAT_W-1:0]       out_status,
  input logic                              out_last
);

  logic accept;
  logic single_act;
  logic known_act;

  assign accept     = start && !busy;
  assign single_act = (in_action == sukt_pkg::ACT_INSERT) ||
                      (in_action == sukt_pkg::ACT_DELETE) ||
                      (in_action == sukt_pkg::ACT_SEARCH);
  assign known_act  = single_act ||
                      (in_action == sukt_pkg::ACT_LIST_ASC) ||
                      (in_action == sukt_pkg::ACT_LIST_DESC);

  // A key operation answers with exactly one final result in the next cycle.
  `SUKT_ASSERT_NEXT(a_single_result, accept && single_act, out_valid && out_last, "key operation result missing")
  // An unknown action produces no result.
  `SUKT_ASSERT_NEXT(a_unknown_silent, accept && !known_act, !out_valid, "result for unknown action")
  // Any error status ends the item.
  `SUKT_ASSERT_NOW(a_error_last, out_valid && (out_status != sukt_pkg::STAT_OK), out_last, "error status not final")
  // A list streams without gaps until its final result.
  `SUKT_ASSERT_NEXT(a_list_contiguous, out_valid && !out_last, out_valid, "gap inside list")
  // The block is free again once the final result is shown.
  `SUKT_ASSERT_NOW(a_last_frees, out_valid && out_last, !busy, "busy after final result")

endmodule

bind sorted_unique_key_table sukt_checker u_sukt_checker (.*);
